[rtl/ipr_pkg.sv]
// Types and constants shared by the indexed pixel to RGBA converter.
`default_nettype none
package ipr_pkg;

	localparam logic       OP_LOAD     = 1'b0;
	localparam logic       OP_CONVERT  = 1'b1;

	localparam logic [1:0] MODE_IDX4   = 2'd0;
	localparam logic [1:0] MODE_IDX8   = 2'd1;
	localparam logic [1:0] MODE_DIRECT = 2'd2;

	localparam logic [7:0] ALPHA_CLEAR = 8'd0;
	localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

	typedef struct packed {
		logic        operation;
		logic [7:0]  palette_index;
		logic [15:0] palette_entry;
		logic [15:0] pixel_word;
		logic        end_of_image;
	} in_item_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
		logic       last_of_word;
		logic       image_done;
	} out_item_t;

	// Palette write request from the sequencer.
	typedef struct packed {
		logic        en;
		logic [7:0]  index;
		logic [15:0] entry;
	} pal_wr_t;

	// One pixel to be looked up and formatted.
	typedef struct packed {
		logic [7:0]  index;
		logic        direct;
		logic        indexed4;
		logic        last;
		logic        done;
		logic [14:0] colour;
	} pix_req_t;

	// Pixel control after the palette read.
	typedef struct packed {
		logic        direct;
		logic        indexed4;
		logic        in_range;
		logic        last;
		logic        done;
		logic [14:0] colour;
	} pix_meta_t;

endpackage
`default_nettype wire

[rtl/indexed_pixel_to_rgba.sv]
// Top level of the indexed pixel to RGBA converter.
//
// Items arrive on the req channel (req_valid, req_stall, req_item). A load item
// writes one palette slot; a convert item turns one 16-bit image word into
// RGBA8 pixels that leave on the pix channel (pix_valid, pix_stall, pix_item).
// A transfer happens on a rising edge where valid is high and stall is low.
// The pixel mode register is written through cfg_we and cfg_data; the user must
// write it only while idle, which the block itself does not enforce.
// The first pixel of a word passes the input register, the palette read stage
// and the output register. While the receiver does not stall, the output runs
// at one pixel per cycle, set by the sequencer handing one palette read per
// cycle; a word gives four pixels in 4-bit mode, two in 8-bit mode and one in
// direct mode, a load none. Reads go to a memory with a registered read port.
//
// Reset clears the pipeline and sets the mode to 4-bit indexed; the palette
// holds nothing defined until it is loaded. When the receiver stalls, the
// output register holds its pixel, the stages behind it fill, and req_stall
// rises once the sequencer can no longer issue.
`default_nettype none
module indexed_pixel_to_rgba #(
	parameter int PALETTE_ENTRIES = 256
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 cfg_we,
	input  wire  [1:0]          cfg_data,
	input  wire                 req_valid,
	output logic                req_stall,
	input  ipr_pkg::in_item_t   req_item,
	output logic                pix_valid,
	input  wire                 pix_stall,
	output ipr_pkg::out_item_t  pix_item
);
	import ipr_pkg::*;

	logic [1:0] pixel_mode_q;
	pal_wr_t    pal_wr;
	logic       pix_req_valid;
	logic       pix_req_ready;
	pix_req_t   pix_req;
	logic       meta_valid;
	logic       meta_ready;
	pix_meta_t  meta;
	logic [15:0] rd_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_mode_q <= MODE_IDX4;
		end else if (cfg_we) begin
			pixel_mode_q <= cfg_data;
		end
	end

	ipr_seq u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.pixel_mode    (pixel_mode_q),
		.req_valid     (req_valid),
		.req_stall     (req_stall),
		.req_item      (req_item),
		.pal_wr        (pal_wr),
		.pix_req_valid (pix_req_valid),
		.pix_req_ready (pix_req_ready),
		.pix_req       (pix_req)
	);

	ipr_lookup #(
		.PALETTE_ENTRIES (PALETTE_ENTRIES)
	) u_lookup (
		.clk           (clk),
		.arst_n        (arst_n),
		.pal_wr        (pal_wr),
		.pix_req_valid (pix_req_valid),
		.pix_req_ready (pix_req_ready),
		.pix_req       (pix_req),
		.meta_valid    (meta_valid),
		.meta_ready    (meta_ready),
		.meta          (meta),
		.rd_data       (rd_data)
	);

	ipr_out u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.meta_valid (meta_valid),
		.meta_ready (meta_ready),
		.meta       (meta),
		.rd_data    (rd_data),
		.pix_valid  (pix_valid),
		.pix_stall  (pix_stall),
		.pix_item   (pix_item)
	);

endmodule
`default_nettype wire

[rtl/ipr_seq.sv]
// Input register and per-pixel sequencer that splits an image word into pixels.
`default_nettype none
module ipr_seq (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire  [1:0]          pixel_mode,
	input  wire                 req_valid,
	output logic                req_stall,
	input  ipr_pkg::in_item_t   req_item,
	output ipr_pkg::pal_wr_t    pal_wr,
	output logic                pix_req_valid,
	input  wire                 pix_req_ready,
	output ipr_pkg::pix_req_t   pix_req
);
	import ipr_pkg::*;

	logic       valid_s1;
	in_item_t   item_s1;
	logic [1:0] k_q;

	logic       convert_ok;
	logic       last;
	logic       issue;
	logic       s1_done;
	logic       accept;
	logic [7:0] index;

	assign convert_ok = (item_s1.operation == OP_CONVERT) &&
		((pixel_mode == MODE_IDX4) || (pixel_mode == MODE_IDX8) ||
		 (pixel_mode == MODE_DIRECT));

	always_comb begin
		last  = 1'b1;
		index = 8'd0;
		case (pixel_mode)
			MODE_IDX4: begin
				last = (k_q == 2'd3);
				case (k_q)
					2'd0:    index = {4'd0, item_s1.pixel_word[3:0]};
					2'd1:    index = {4'd0, item_s1.pixel_word[7:4]};
					2'd2:    index = {4'd0, item_s1.pixel_word[11:8]};
					default: index = {4'd0, item_s1.pixel_word[15:12]};
				endcase
			end
			MODE_IDX8: begin
				last  = k_q[0];
				index = k_q[0] ? item_s1.pixel_word[15:8] : item_s1.pixel_word[7:0];
			end
			default: begin
				last  = 1'b1;
				index = 8'd0;
			end
		endcase
	end

	assign issue         = valid_s1 && convert_ok && pix_req_ready;
	assign s1_done       = valid_s1 && (!convert_ok || (issue && last));
	assign req_stall     = valid_s1 && !s1_done;
	assign accept        = req_valid && !req_stall;
	assign pix_req_valid = valid_s1 && convert_ok;

	assign pix_req.index    = index;
	assign pix_req.direct   = (pixel_mode == MODE_DIRECT);
	assign pix_req.indexed4 = (pixel_mode == MODE_IDX4);
	assign pix_req.last     = last;
	assign pix_req.done     = last && item_s1.end_of_image;
	assign pix_req.colour   = item_s1.pixel_word[14:0];

	// A load item writes the palette in its single cycle in this stage.
	assign pal_wr.en    = valid_s1 && (item_s1.operation == OP_LOAD);
	assign pal_wr.index = item_s1.palette_index;
	assign pal_wr.entry = item_s1.palette_entry;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			k_q      <= 2'd0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (s1_done) begin
				valid_s1 <= 1'b0;
			end
			if (s1_done) begin
				k_q <= 2'd0;
			end else if (issue) begin
				k_q <= k_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= req_item;
		end
	end

endmodule
`default_nettype wire

[rtl/ipr_lookup.sv]
// Palette memory with its registered read stage.
`default_nettype none
module ipr_lookup #(
	parameter int PALETTE_ENTRIES = 256
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  ipr_pkg::pal_wr_t    pal_wr,
	input  wire                 pix_req_valid,
	output logic                pix_req_ready,
	input  ipr_pkg::pix_req_t   pix_req,
	output logic                meta_valid,
	input  wire                 meta_ready,
	output ipr_pkg::pix_meta_t  meta,
	output logic [15:0]         rd_data
);
	import ipr_pkg::*;

	localparam int         AW      = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
	localparam logic [8:0] ENTRIES = 9'(PALETTE_ENTRIES);

	logic [15:0]   mem [PALETTE_ENTRIES];
	logic          valid_s2;
	pix_meta_t     meta_s2;
	logic [15:0]   rd_s2;

	logic          wr_ok;
	logic          rd_ok;
	logic [AW-1:0] rd_addr;

	assign wr_ok   = pal_wr.en && ({1'b0, pal_wr.index} < ENTRIES);
	assign rd_ok   = ({1'b0, pix_req.index} < ENTRIES);
	assign rd_addr = rd_ok ? pix_req.index[AW-1:0] : '0;

	assign pix_req_ready = !valid_s2 || meta_ready;

	always_ff @(posedge clk) begin
		if (wr_ok) begin
			mem[pal_wr.index[AW-1:0]] <= pal_wr.entry;
		end
		if (pix_req_ready && pix_req_valid) begin
			rd_s2            <= mem[rd_addr];
			meta_s2.direct   <= pix_req.direct;
			meta_s2.indexed4 <= pix_req.indexed4;
			meta_s2.in_range <= rd_ok;
			meta_s2.last     <= pix_req.last;
			meta_s2.done     <= pix_req.done;
			meta_s2.colour   <= pix_req.colour;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (pix_req_ready) begin
			valid_s2 <= pix_req_valid;
		end
	end

	assign meta_valid = valid_s2;
	assign meta       = meta_s2;
	assign rd_data    = rd_s2;

endmodule
`default_nettype wire

[rtl/ipr_out.sv]
// Colour expansion and the output register of the pixel channel.
`default_nettype none
module ipr_out (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 meta_valid,
	output logic                meta_ready,
	input  ipr_pkg::pix_meta_t  meta,
	input  wire  [15:0]         rd_data,
	output logic                pix_valid,
	input  wire                 pix_stall,
	output ipr_pkg::out_item_t  pix_item
);
	import ipr_pkg::*;

	logic      valid_q;
	out_item_t item_q;
	out_item_t item_d;
	logic [15:0] colour;

	always_comb begin
		if (meta.direct) begin
			colour = {1'b0, meta.colour};
		end else if (meta.in_range) begin
			colour = rd_data;
		end else begin
			colour = 16'd0;
		end
		item_d.red          = {colour[4:0], 3'd0};
		item_d.green        = {colour[9:5], 3'd0};
		item_d.blue         = {colour[14:10], 3'd0};
		// Black without the flag is the transparent color in 4-bit mode.
		item_d.alpha        = (meta.indexed4 && !colour[15] && (colour[14:0] == 15'd0)) ?
			ALPHA_CLEAR : ALPHA_OPAQUE;
		item_d.last_of_word = meta.last;
		item_d.image_done   = meta.done;
	end

	assign meta_ready = !valid_q || !pix_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (meta_ready) begin
			valid_q <= meta_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (meta_ready && meta_valid) begin
			item_q <= item_d;
		end
	end

	assign pix_valid = valid_q;
	assign pix_item  = item_q;

endmodule
`default_nettype wire
